FILE: rtl/sound_voice_allocator_top_assert.svh
// Assertion macros used by the top-level RTL file.
// SVA_CHECK gates the check with reset, SVA_CHECK_ALWAYS also runs during reset.
`ifndef SOUND_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define SOUND_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SVA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SVA_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVA_CHECK(label, prop, msg)
`define SVA_CHECK_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/svalloc_pkg.sv
package svalloc_pkg;

  localparam int DEF_MAX_SOURCES    = 16;
  localparam int DEF_BUFFER_ID_BITS = 10;

  localparam int ACTIVE_W = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd6;

  // choice codes
  localparam logic [1:0] KIND_IDLE  = 2'd0;
  localparam logic [1:0] KIND_SAME  = 2'd1;
  localparam logic [1:0] KIND_STEAL = 2'd2;

  localparam int VOL_PCT_W   = 7;
  localparam int PITCH_PCT_W = 8;
  localparam logic signed [15:0] VOL_MIN   = 16'sd0;
  localparam logic signed [15:0] VOL_MAX   = 16'sd100;
  localparam logic signed [15:0] PITCH_MIN = 16'sd50;
  localparam logic signed [15:0] PITCH_MAX = 16'sd150;

  // register index
  localparam logic REG_ACTIVE_SOURCES = 1'b0;

  function automatic logic [VOL_PCT_W-1:0] clamp_volume(input logic signed [15:0] v);
    logic [VOL_PCT_W-1:0] r;
    if (v < VOL_MIN) r = VOL_MIN[VOL_PCT_W-1:0];
    else if (v > VOL_MAX) r = VOL_MAX[VOL_PCT_W-1:0];
    else r = v[VOL_PCT_W-1:0];
    return r;
  endfunction

  function automatic logic [PITCH_PCT_W-1:0] clamp_pitch(input logic signed [15:0] v);
    logic [PITCH_PCT_W-1:0] r;
    if (v < PITCH_MIN) r = PITCH_MIN[PITCH_PCT_W-1:0];
    else if (v > PITCH_MAX) r = PITCH_MAX[PITCH_PCT_W-1:0];
    else r = v[PITCH_PCT_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/svalloc_order.sv
// Recency order store. Entries not written since reset or clear read as
// their own position (identity order).
module svalloc_order import svalloc_pkg::*; #(
  parameter int MAX_SOURCES = DEF_MAX_SOURCES,
  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic [IDX_W-1:0] raddr,
  output logic [IDX_W-1:0] rd_val,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [IDX_W-1:0] wdata
);

  logic [IDX_W-1:0]       mem [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] vld;
  logic [IDX_W-1:0]       mem_q;
  logic [IDX_W-1:0]       raddr_q;
  logic                   vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q   <= mem[raddr];
    raddr_q <= raddr;
    vld_q   <= vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  assign rd_val = vld_q ? mem_q : raddr_q;

endmodule

FILE: rtl/svalloc_bufmem.sv
// Attached buffer ids per source, with a has-buffer flag per source.
module svalloc_bufmem import svalloc_pkg::*; #(
  parameter int MAX_SOURCES    = DEF_MAX_SOURCES,
  parameter int BUFFER_ID_BITS = DEF_BUFFER_ID_BITS,
  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [IDX_W-1:0]          raddr,
  output logic [BUFFER_ID_BITS-1:0] rd_buf,
  output logic [MAX_SOURCES-1:0]    has_buf,
  input  logic                      we,
  input  logic [IDX_W-1:0]          waddr,
  input  logic [BUFFER_ID_BITS-1:0] wdata
);

  logic [BUFFER_ID_BITS-1:0] mem [MAX_SOURCES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_buf <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_buf <= '0;
    end else if (we) begin
      has_buf[waddr] <= 1'b1;
    end
  end

endmodule

FILE: rtl/sound_voice_allocator_top.sv
// Flow: n = active sources (1..MAX_SOURCES). A scan in recency order, then pick
//   (skipped when the scan finds an idle source), update and reorder (a read and a
//   write per position moved, plus a final write of the chosen source), then the result register.
// Throughput: one request at a time; the next is taken the cycle after the result
//   is registered, and the result register waits while the output is not ready.
// Reset (rst, synchronous): identity order, no buffers attached, active_sources 6.
`include "sound_voice_allocator_top_assert.svh"
module sound_voice_allocator_top import svalloc_pkg::*; #(
  parameter int MAX_SOURCES    = DEF_MAX_SOURCES,
  parameter int BUFFER_ID_BITS = DEF_BUFFER_ID_BITS,
  localparam int S_TDATA_W = ((BUFFER_ID_BITS + 48 + 7) / 8) * 8,
  localparam int M_TDATA_W = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  // request: buffer_id, playing_mask[15:0], volume[15:0], pitch[15:0]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  // result: source_index[3:0], switch_buffer, choice_kind[1:0],
  //         volume_pct[6:0], pitch_pct[7:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  // config
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CNT_W = $clog2(MAX_SOURCES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_SHRD = 3'd4;
  localparam logic [2:0] S_SHWR = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Effective source count: zero acts as one, large values saturate.
  function automatic logic [CNT_W-1:0] src_count(input logic [ACTIVE_W-1:0] a);
    int c;
    if (a == '0) c = 1;
    else if (int'(a) > MAX_SOURCES) c = MAX_SOURCES;
    else c = int'(a);
    return CNT_W'(c);
  endfunction

  logic [2:0] state;

  // configuration
  logic [ACTIVE_W-1:0] active_sources;
  logic [CNT_W-1:0]    nsrc;
  logic [IDX_W-1:0]    n_last;
  logic                cfg_wr;
  logic [CNT_W-1:0]    cfg_cnt;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SOURCES);
  assign prdata  = (paddr[2] == REG_ACTIVE_SOURCES) ? 32'(active_sources) : 32'd0;
  assign cfg_cnt = src_count(pwdata[ACTIVE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sources <= ACTIVE_RESET;
      nsrc           <= src_count(ACTIVE_RESET);
      n_last         <= IDX_W'(src_count(ACTIVE_RESET) - 1'b1);
    end else if (cfg_wr) begin
      active_sources <= pwdata[ACTIVE_W-1:0];
      nsrc           <= cfg_cnt;
      n_last         <= IDX_W'(cfg_cnt - 1'b1);
    end
  end

  // latched request
  logic [BUFFER_ID_BITS-1:0] req_buf;
  logic [15:0]               req_mask;
  logic signed [15:0]        req_vol;
  logic signed [15:0]        req_pitch;

  // scan pipeline: issue -> order read -> buffer read -> compare
  logic [CNT_W-1:0]    rd_p;
  logic                issue_v;
  logic                st1_v;
  logic [IDX_W-1:0]    st1_p;
  logic [IDX_W-1:0]    s1;
  logic [5:0]          s1_ext;
  logic                st2_v;
  logic [IDX_W-1:0]    st2_p;
  logic [IDX_W-1:0]    st2_s;
  logic                st2_hb;
  logic                st2_busy;
  logic                ev_idle;
  logic                ev_same;
  logic                ev_sw;
  logic                scan_done;

  // scan results
  logic                found_same;
  logic [IDX_W-1:0]    same_pos;
  logic [IDX_W-1:0]    same_src;
  logic [IDX_W-1:0]    p0_src;
  logic                p0_sw;

  // chosen source
  logic [IDX_W-1:0]    ch_src;
  logic [IDX_W-1:0]    sh_p;
  logic [1:0]          ch_kind;
  logic                ch_sw;
  logic [5:0]          ch_src_ext;

  // store ports
  logic [IDX_W-1:0]          ord_raddr;
  logic [IDX_W-1:0]          ord_rd;
  logic                      ord_we;
  logic [IDX_W-1:0]          ord_wdata;
  logic [BUFFER_ID_BITS-1:0] buf_rd;
  logic [MAX_SOURCES-1:0]    has_buf;
  logic                      buf_we;

  assign s_tready = (state == S_IDLE);

  assign issue_v = (state == S_SCAN) && (rd_p < nsrc);
  assign s1      = ord_rd;
  assign s1_ext  = 6'(s1);

  // shared compare unit
  assign ev_idle   = !st2_hb || !st2_busy;
  assign ev_same   = st2_hb && (buf_rd == req_buf);
  assign ev_sw     = !st2_hb || (buf_rd != req_buf);
  assign scan_done = st2_v && (ev_idle || (st2_p == n_last));

  assign ord_raddr = (state == S_SHRD) ? IDX_W'(sh_p + 1'b1) : rd_p[IDX_W-1:0];
  // shift down one place at a time; the chosen source lands at the top
  assign ord_we    = (state == S_SHWR) || ((state == S_SHRD) && (sh_p == n_last));
  assign ord_wdata = (state == S_SHWR) ? ord_rd : ch_src;
  assign buf_we    = (state == S_UPD);

  svalloc_order #(.MAX_SOURCES(MAX_SOURCES)) u_order (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_wr),
    .raddr  (ord_raddr),
    .rd_val (ord_rd),
    .we     (ord_we),
    .waddr  (sh_p),
    .wdata  (ord_wdata)
  );

  svalloc_bufmem #(
    .MAX_SOURCES    (MAX_SOURCES),
    .BUFFER_ID_BITS (BUFFER_ID_BITS)
  ) u_bufmem (
    .clk     (clk),
    .rst     (rst),
    .raddr   (s1),
    .rd_buf  (buf_rd),
    .has_buf (has_buf),
    .we      (buf_we),
    .waddr   (ch_src),
    .wdata   (req_buf)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_buf   <= s_tdata[BUFFER_ID_BITS-1:0];
      req_mask  <= s_tdata[BUFFER_ID_BITS+15:BUFFER_ID_BITS];
      req_vol   <= s_tdata[BUFFER_ID_BITS+31:BUFFER_ID_BITS+16];
      req_pitch <= s_tdata[BUFFER_ID_BITS+47:BUFFER_ID_BITS+32];
    end
    st1_p    <= rd_p[IDX_W-1:0];
    st2_p    <= st1_p;
    st2_s    <= s1;
    st2_hb   <= has_buf[s1];
    // playing bits above source 15 do not exist
    st2_busy <= (s1_ext[5:4] == 2'b00) && req_mask[s1_ext[3:0]];
  end

  assign ch_src_ext = 6'(ch_src);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_p       <= '0;
      st1_v      <= 1'b0;
      st2_v      <= 1'b0;
      found_same <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      st1_v <= issue_v && !scan_done;
      st2_v <= st1_v && (state == S_SCAN) && !scan_done;
      // S_OUT reloads the result register itself
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state      <= S_SCAN;
            rd_p       <= '0;
            found_same <= 1'b0;
          end
        end
        S_SCAN: begin
          if (issue_v) begin
            rd_p <= rd_p + 1'b1;
          end
          if (st2_v) begin
            if (ev_idle) begin
              sh_p    <= st2_p;
              ch_src  <= st2_s;
              ch_kind <= KIND_IDLE;
              ch_sw   <= ev_sw;
              state   <= S_UPD;
            end else begin
              if (ev_same && !found_same) begin
                found_same <= 1'b1;
                same_pos   <= st2_p;
                same_src   <= st2_s;
              end
              if (st2_p == '0) begin
                p0_src <= st2_s;
                p0_sw  <= ev_sw;
              end
              if (st2_p == n_last) begin
                state <= S_PICK;
              end
            end
          end
        end
        S_PICK: begin
          if (found_same) begin
            sh_p    <= same_pos;
            ch_src  <= same_src;
            ch_kind <= KIND_SAME;
            ch_sw   <= 1'b0;
          end else begin
            sh_p    <= '0;
            ch_src  <= p0_src;
            ch_kind <= KIND_STEAL;
            ch_sw   <= p0_sw;
          end
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_SHRD;
        end
        S_SHRD: begin
          if (sh_p == n_last) begin
            state <= S_OUT;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          sh_p  <= IDX_W'(sh_p + 1'b1);
          state <= S_SHRD;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, clamp_pitch(req_pitch), clamp_volume(req_vol),
                         ch_kind, ch_sw, ch_src_ext[3:0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SVA_CHECK(a_same_no_switch, m_tvalid && (m_tdata[6:5] == KIND_SAME) |-> !m_tdata[4], "same-buffer choice flagged a switch")
  `SVA_CHECK(a_scan_in_range, st2_v |-> (CNT_W'(st2_p) < nsrc), "scan position past active sources")
  `SVA_CHECK(a_shift_in_range, ord_we |-> (sh_p <= n_last), "reorder write past last active source")
  `SVA_CHECK_ALWAYS(a_reset_quiet, rst |=> !m_tvalid && (state == S_IDLE), "result pending after reset")

endmodule
